// ===== sv/platform_interrupt_controller_top_macros.svh =====
// assertion macros shared by the interrupt controller modules
// no dependencies; included by the files that carry assertions
`ifndef PLATFORM_INTERRUPT_CONTROLLER_TOP_MACROS_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define PIC_ASSERT_IMPLY(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pic assertion failed");

// next-cycle implication
`define PIC_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pic assertion failed");

`endif

// ===== sv/pic_pkg.sv =====
// types and constants for the platform interrupt controller
// no dependencies
package pic_pkg;

   localparam int ADDR_W      = 26;
   localparam int DATA_W      = 32;
   localparam int SRCN_W      = 7;
   localparam int LINES_W     = 4;
   localparam int STRIDE_W    = 17;
   localparam int COUNT_W     = 8;
   localparam int THR_W       = 3;
   localparam int ARITH_W     = 28;
   localparam int OFF_W       = 22;
   localparam int CSR_AW      = 5;
   localparam int WORD_BITS   = 32;
   localparam int CLAIM_OFFSET = 4;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_LEVEL = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      SEL_NONE = 3'd0,
      SEL_PRIO = 3'd1,
      SEL_PEND = 3'd2,
      SEL_EN   = 3'd3,
      SEL_CTX  = 3'd4
   } sel_type;

   typedef enum logic [2:0] {
      CSR_PRIO_BASE  = 3'd0,
      CSR_PEND_BASE  = 3'd1,
      CSR_EN_BASE    = 3'd2,
      CSR_EN_STRIDE  = 3'd3,
      CSR_CTX_BASE   = 3'd4,
      CSR_CTX_STRIDE = 3'd5,
      CSR_SOURCES    = 3'd6,
      CSR_HIGH_THR   = 3'd7
   } csr_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   prio_base;
      logic [ADDR_W-1:0]   pend_base;
      logic [ADDR_W-1:0]   en_base;
      logic [STRIDE_W-1:0] en_stride;
      logic [ADDR_W-1:0]   ctx_base;
      logic [STRIDE_W-1:0] ctx_stride;
      logic [COUNT_W-1:0]  sources;
      logic [THR_W-1:0]    high_thr;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic div_step;
      logic apply;
      logic scan_start;
      logic scan_step;
      logic claim;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic needs_div;
      logic div_done;
      logic claim_read;
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage

// ===== sv/pic_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module pic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/pic_ctrl.sv =====
// sequencer for the interrupt controller: decode, divide, apply, scan, claim, finish
// depends on pic_pkg and the assertion macro header
`include "platform_interrupt_controller_top_macros.svh"

module pic_ctrl import pic_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_DECODE     = 8'b0000_0010,
      ST_DIVIDE     = 8'b0000_0100,
      ST_APPLY      = 8'b0000_1000,
      ST_SCAN_CLAIM = 8'b0001_0000,
      ST_CLAIM      = 8'b0010_0000,
      ST_SCAN_LINES = 8'b0100_0000,
      ST_FINISH     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (!sts.needs_div || sts.div_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply      = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = sts.claim_read ? ST_SCAN_CLAIM : ST_SCAN_LINES;
         end
         ST_SCAN_CLAIM: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_CLAIM;
            end
         end
         ST_CLAIM: begin
            cmd.claim      = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = ST_SCAN_LINES;
         end
         ST_SCAN_LINES: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   `PIC_ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && !req_stall, state_ff == ST_DECODE)
   `PIC_ASSERT_IMPLY(a_finish_free, clock, reset, cmd.finish, sts.out_free)
   `PIC_ASSERT_IMPLY(a_finish_scanned, clock, reset, cmd.finish, sts.scan_done)

endmodule

// ===== sv/pic_dp.sv =====
// datapath: item registers, window decode, stride divider, stores, priority scan
// depends on pic_pkg and pic_ram
module pic_dp import pic_pkg::*; #(
   parameter int MAX_SOURCES   = 128,
   parameter int NUM_CONTEXTS  = 4,
   parameter int PRIORITY_BITS = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [1:0]         req_opcode,
   input  logic [ADDR_W-1:0]  req_bus_address,
   input  logic [DATA_W-1:0]  req_bus_write_data,
   input  logic [SRCN_W-1:0]  req_source_number,
   input  logic               req_source_level,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DATA_W-1:0]  rsp_read_data,
   output logic               rsp_access_error,
   output logic [LINES_W-1:0] rsp_context_interrupts
);

   localparam int WORDS = (MAX_SOURCES + 31) / 32;
   localparam int BITS  = WORDS * WORD_BITS;
   localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SRC_W = $clog2(BITS);
   localparam int NW    = $clog2(MAX_SOURCES + 1);
   localparam int CTX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
   localparam int PB    = PRIORITY_BITS;

   // item registers
   op_type              op_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [DATA_W-1:0]   wdata_ff;
   logic [SRCN_W-1:0]   src_ff;
   logic                lvl_ff;

   // decode and divider state
   sel_type             sel_ff, sel_d;
   logic                mis_ff;
   logic [OFF_W-1:0]    rem_ff;
   logic [STRIDE_W-1:0] div_ff;
   logic [CTX_W-1:0]    quot_ff;

   // stores
   logic [BITS-1:0]     pend_ff, claim_ff;
   logic [BITS-1:0]     en_ff [NUM_CONTEXTS];
   logic [PB-1:0]       thr_ff [NUM_CONTEXTS];
   logic [MAX_SOURCES-1:0] prio_vld_ff;

   // scan state
   logic [NW-1:0]       id_ff;
   logic                s_vld_ff;
   logic [SRC_W-1:0]    s_id_ff;
   logic [SRC_W-1:0]    best_id_ff [NUM_CONTEXTS];
   logic [PB-1:0]       best_p_ff [NUM_CONTEXTS];

   // read path and result
   logic                prd_ff, ram_vld_ff;
   logic [DATA_W-1:0]   rd_ff;
   logic                err_ff;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_read_data_ff;
   logic                rsp_access_error_ff;
   logic [LINES_W-1:0]  rsp_lines_ff;

   // source count in use
   logic [31:0]         n32, words32;
   logic [NW-1:0]       n_used;
   assign n32     = (32'(cfg.sources) > 32'(MAX_SOURCES)) ? 32'(MAX_SOURCES)
                                                           : 32'(cfg.sources);
   assign n_used  = NW'(n32);
   assign words32 = (n32 + 32'd31) >> 5;

   // window compares
   logic [ARITH_W-1:0] a, prio_lo, pend_lo, en_lo, ctx_lo;
   logic               hit_prio, hit_pend, hit_en, hit_ctx, misaligned;
   assign a       = ARITH_W'(addr_ff);
   assign prio_lo = ARITH_W'(cfg.prio_base);
   assign pend_lo = ARITH_W'(cfg.pend_base);
   assign en_lo   = ARITH_W'(cfg.en_base);
   assign ctx_lo  = ARITH_W'(cfg.ctx_base);
   assign misaligned = (addr_ff[1:0] != 2'b00);
   assign hit_prio = (n32 != 32'd0) && (a >= prio_lo)
                  && (a < prio_lo + ARITH_W'((n32 - 32'd1) << 2));
   assign hit_pend = (a >= pend_lo) && (a < pend_lo + ARITH_W'(words32 << 2));
   assign hit_en   = (cfg.en_stride != '0) && (a >= en_lo)
                  && (a < en_lo + ARITH_W'(NUM_CONTEXTS) * ARITH_W'(cfg.en_stride));
   assign hit_ctx  = (cfg.ctx_stride != '0) && (a >= ctx_lo)
                  && (a < ctx_lo + ARITH_W'(NUM_CONTEXTS) * ARITH_W'(cfg.ctx_stride));

   // first matching window wins
   always_comb begin
      if (misaligned) sel_d = SEL_NONE;
      else if (hit_prio) sel_d = SEL_PRIO;
      else if (hit_pend) sel_d = SEL_PEND;
      else if (hit_en) sel_d = SEL_EN;
      else if (hit_ctx) sel_d = SEL_CTX;
      else sel_d = SEL_NONE;
   end

   // apply-time decode
   logic              is_wr, is_bus, en_ok, thr_reg, claim_reg, mapped, err_d;
   logic [SRC_W-1:0]  prio_id;
   logic [WW-1:0]     pend_w, en_w;
   logic [31:0]       en_w32;
   logic [DATA_W-1:0] rd_d;
   assign is_wr     = (op_ff == OP_WRITE);
   assign is_bus    = (op_ff == OP_READ) || is_wr;
   assign prio_id   = SRC_W'(((a - prio_lo) >> 2) + ARITH_W'(1));
   assign pend_w    = WW'((a - pend_lo) >> 2);
   assign en_w32    = 32'(rem_ff >> 2);
   assign en_ok     = (en_w32 < words32);
   assign en_w      = WW'(en_w32);
   assign thr_reg   = (rem_ff == '0);
   assign claim_reg = (rem_ff == OFF_W'(CLAIM_OFFSET));
   assign mapped    = (sel_ff == SEL_PRIO) || (sel_ff == SEL_PEND)
                   || ((sel_ff == SEL_EN) && en_ok)
                   || ((sel_ff == SEL_CTX) && (thr_reg || claim_reg));
   assign err_d     = is_bus && (mis_ff || !mapped || ((sel_ff == SEL_PEND) && is_wr));

   // bus read data from flop stores
   always_comb begin
      case (sel_ff)
         SEL_PEND: rd_d = pend_ff[{pend_w, 5'd0} +: WORD_BITS];
         SEL_EN:   rd_d = en_ff[quot_ff][{en_w, 5'd0} +: WORD_BITS];
         SEL_CTX:  rd_d = thr_reg ? DATA_W'(thr_ff[quot_ff]) : '0;
         default:  rd_d = '0;
      endcase
   end

   // priority ram
   logic                     ram_we;
   logic [SRC_W-1:0]         ram_addr;
   logic [PB-1:0]            ram_q;
   logic [PB-1:0]            s_prio;
   assign ram_we   = cmd.apply && is_wr && (sel_ff == SEL_PRIO);
   assign ram_addr = cmd.scan_step ? id_ff[SRC_W-1:0] : prio_id;
   assign s_prio   = ram_vld_ff ? ram_q : '0;

   pic_ram #(.WIDTH(PB), .DEPTH(MAX_SOURCES)) u_prio_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (wdata_ff[PB-1:0]),
      .rdata (ram_q)
   );

   // item capture, decode and divider
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_opcode);
         addr_ff  <= req_bus_address;
         wdata_ff <= req_bus_write_data;
         src_ff   <= req_source_number;
         lvl_ff   <= req_source_level;
      end
      if (cmd.decode) begin
         sel_ff  <= is_bus ? sel_d : SEL_NONE;
         mis_ff  <= misaligned;
         quot_ff <= '0;
         if (sel_d == SEL_EN) begin
            rem_ff <= OFF_W'(a - en_lo);
            div_ff <= cfg.en_stride;
         end else begin
            rem_ff <= OFF_W'(a - ctx_lo);
            div_ff <= cfg.ctx_stride;
         end
      end else if (cmd.div_step && (rem_ff >= OFF_W'(div_ff))) begin
         rem_ff  <= rem_ff - OFF_W'(div_ff);
         quot_ff <= quot_ff + CTX_W'(1);
      end
   end

   // stores, read data and claim
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         claim_ff    <= '0;
         prio_vld_ff <= '0;
         prd_ff      <= 1'b0;
         for (int c = 0; c < NUM_CONTEXTS; c++) begin
            en_ff[c]  <= '0;
            thr_ff[c] <= '0;
         end
      end else begin
         prd_ff <= cmd.apply && (op_ff == OP_READ) && (sel_ff == SEL_PRIO) && !err_d;
         if (ram_we) begin
            prio_vld_ff[prio_id] <= 1'b1;
         end
         if (cmd.apply) begin
            if ((op_ff == OP_LEVEL) && (32'(src_ff) >= 32'd1) && (32'(src_ff) < n32)) begin
               pend_ff[SRC_W'(src_ff)] <= lvl_ff;
            end
            if (is_wr && (sel_ff == SEL_EN) && en_ok) begin
               en_ff[quot_ff][{en_w, 5'd0} +: WORD_BITS] <= wdata_ff;
            end
            if (is_wr && (sel_ff == SEL_CTX) && thr_reg
                && (wdata_ff <= DATA_W'(cfg.high_thr))) begin
               thr_ff[quot_ff] <= wdata_ff[PB-1:0];
            end
            if (is_wr && (sel_ff == SEL_CTX) && claim_reg && (wdata_ff < n32)) begin
               claim_ff[SRC_W'(wdata_ff)] <= 1'b0;
            end
         end
         if (cmd.claim && (best_id_ff[quot_ff] != '0)) begin
            pend_ff[best_id_ff[quot_ff]]  <= 1'b0;
            claim_ff[best_id_ff[quot_ff]] <= 1'b1;
         end
      end
   end

   // result data and error
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         err_ff <= err_d;
         rd_ff  <= (is_bus && !is_wr && !err_d) ? rd_d : '0;
      end else if (prd_ff) begin
         rd_ff <= DATA_W'(s_prio);
      end else if (cmd.claim) begin
         rd_ff <= DATA_W'(best_id_ff[quot_ff]);
      end
      ram_vld_ff <= prio_vld_ff[ram_addr];
   end

   // priority scan: one source a cycle, all contexts side by side
   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
         id_ff    <= '0;
      end else if (cmd.scan_start) begin
         s_vld_ff <= 1'b0;
         id_ff    <= NW'(1);
      end else begin
         s_vld_ff <= cmd.scan_step && (id_ff < n_used);
         if (cmd.scan_step && (id_ff < n_used)) begin
            id_ff <= id_ff + NW'(1);
         end
      end
      s_id_ff <= id_ff[SRC_W-1:0];
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
         if (cmd.scan_start) begin
            best_id_ff[c] <= '0;
            best_p_ff[c]  <= '0;
         end else if (s_vld_ff && pend_ff[s_id_ff] && !claim_ff[s_id_ff]
                      && en_ff[c][s_id_ff] && (s_prio > thr_ff[c])
                      && (s_prio > best_p_ff[c])) begin
            best_id_ff[c] <= s_id_ff;
            best_p_ff[c]  <= s_prio;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_read_data_ff    <= rd_ff;
         rsp_access_error_ff <= err_ff;
         for (int c = 0; c < LINES_W; c++) begin
            rsp_lines_ff[c] <= (c < NUM_CONTEXTS) ? (best_id_ff[c % NUM_CONTEXTS] != '0)
                                                  : 1'b0;
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_read_data          = rsp_read_data_ff;
   assign rsp_access_error       = rsp_access_error_ff;
   assign rsp_context_interrupts = rsp_lines_ff;

   // status to sequencer
   assign sts.needs_div  = (sel_ff == SEL_EN) || (sel_ff == SEL_CTX);
   assign sts.div_done   = (rem_ff < OFF_W'(div_ff));
   assign sts.claim_read = (op_ff == OP_READ) && (sel_ff == SEL_CTX) && claim_reg && !err_d;
   assign sts.scan_done  = !(id_ff < n_used) && !s_vld_ff;
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== sv/platform_interrupt_controller_top.sv =====
// top level of the platform interrupt controller: register port, sequencer, datapath
// depends on pic_pkg, pic_ctrl, pic_dp
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  opcode, address, write data, source, level
//   rsp      out        rsp_valid/rsp_stall  read data, access error, context lines
//   csr      in         apb psel/penable     8 registers at 4-byte spacing
//
// one transaction at a time: accept, decode, divide, apply, one scan over the sources in use,
// finish; a claim read adds a claim step and a second scan
// the sources are scanned one per cycle through the priority ram port
// reset is synchronous and clears all stores; finish waits while the last result is stalled
// a stalled result holds in its register while the next transaction is accepted
module platform_interrupt_controller_top import pic_pkg::*; #(
   parameter int MAX_SOURCES   = 128,
   parameter int NUM_CONTEXTS  = 4,
   parameter int PRIORITY_BITS = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [ADDR_W-1:0]  req_bus_address,
   input  logic [DATA_W-1:0]  req_bus_write_data,
   input  logic [SRCN_W-1:0]  req_source_number,
   input  logic               req_source_level,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DATA_W-1:0]  rsp_read_data,
   output logic               rsp_access_error,
   output logic [LINES_W-1:0] rsp_context_interrupts,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [DATA_W-1:0]  csr_pwdata,
   output logic [DATA_W-1:0]  csr_prdata,
   output logic               csr_pready
);

   cfg_type cfg_ff;
   csr_type csr_idx;
   cmd_type cmd;
   sts_type sts;

   assign csr_idx    = csr_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prio_base  <= ADDR_W'(4);
         cfg_ff.pend_base  <= ADDR_W'(4096);
         cfg_ff.en_base    <= ADDR_W'(8192);
         cfg_ff.en_stride  <= STRIDE_W'(128);
         cfg_ff.ctx_base   <= ADDR_W'(2097152);
         cfg_ff.ctx_stride <= STRIDE_W'(4096);
         cfg_ff.sources    <= COUNT_W'(128);
         cfg_ff.high_thr   <= THR_W'(7);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            CSR_PRIO_BASE:  cfg_ff.prio_base  <= csr_pwdata[ADDR_W-1:0];
            CSR_PEND_BASE:  cfg_ff.pend_base  <= csr_pwdata[ADDR_W-1:0];
            CSR_EN_BASE:    cfg_ff.en_base    <= csr_pwdata[ADDR_W-1:0];
            CSR_EN_STRIDE:  cfg_ff.en_stride  <= csr_pwdata[STRIDE_W-1:0];
            CSR_CTX_BASE:   cfg_ff.ctx_base   <= csr_pwdata[ADDR_W-1:0];
            CSR_CTX_STRIDE: cfg_ff.ctx_stride <= csr_pwdata[STRIDE_W-1:0];
            CSR_SOURCES:    cfg_ff.sources    <= csr_pwdata[COUNT_W-1:0];
            CSR_HIGH_THR:   cfg_ff.high_thr   <= csr_pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      unique case (csr_idx)
         CSR_PRIO_BASE:  csr_prdata = DATA_W'(cfg_ff.prio_base);
         CSR_PEND_BASE:  csr_prdata = DATA_W'(cfg_ff.pend_base);
         CSR_EN_BASE:    csr_prdata = DATA_W'(cfg_ff.en_base);
         CSR_EN_STRIDE:  csr_prdata = DATA_W'(cfg_ff.en_stride);
         CSR_CTX_BASE:   csr_prdata = DATA_W'(cfg_ff.ctx_base);
         CSR_CTX_STRIDE: csr_prdata = DATA_W'(cfg_ff.ctx_stride);
         CSR_SOURCES:    csr_prdata = DATA_W'(cfg_ff.sources);
         CSR_HIGH_THR:   csr_prdata = DATA_W'(cfg_ff.high_thr);
         default:        csr_prdata = '0;
      endcase
   end

   pic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pic_dp #(
      .MAX_SOURCES   (MAX_SOURCES),
      .NUM_CONTEXTS  (NUM_CONTEXTS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg_ff),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_opcode             (req_opcode),
      .req_bus_address        (req_bus_address),
      .req_bus_write_data     (req_bus_write_data),
      .req_source_number      (req_source_number),
      .req_source_level       (req_source_level),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_read_data          (rsp_read_data),
      .rsp_access_error       (rsp_access_error),
      .rsp_context_interrupts (rsp_context_interrupts)
   );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the platform interrupt controller
// depends on pic_pkg and platform_interrupt_controller_top; predicts each response in a class
module tb import pic_pkg::*;;

   localparam int NCTX  = 4;
   localparam int NSRC  = 128;
   localparam int NWORD = 4;
   localparam int LIMIT = 3000000;
   localparam int DRAIN = 300;

   typedef struct {
      op_type           op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic [SRCN_W-1:0] src;
      logic             lvl;
   } irq_item_type;

   typedef struct {
      logic [DATA_W-1:0]  rdata;
      logic               err;
      logic [LINES_W-1:0] lines;
   } irq_result_type;

   // register file model plus queue of predicted responses
   class irq_scoreboard_type;
      bit [ADDR_W-1:0]   prio_base, pend_base, en_base, ctx_base;
      bit [STRIDE_W-1:0] en_stride, ctx_stride;
      bit [COUNT_W-1:0]  sources;
      bit [THR_W-1:0]    high_thr;
      bit [31:0]         pend[NWORD];
      bit [31:0]         claimed[NWORD];
      bit [31:0]         enab[NWORD*NCTX];
      bit [THR_W-1:0]    prio[NSRC];
      bit [THR_W-1:0]    thr[NCTX];
      irq_result_type    want_q[$];
      int                errors;

      function new();
         prio_base = 4; pend_base = 4096; en_base = 8192; en_stride = 128;
         ctx_base = 2097152; ctx_stride = 4096; sources = 128; high_thr = 7;
         foreach (pend[i]) begin
            pend[i] = 0;
            claimed[i] = 0;
         end
         foreach (enab[i]) enab[i] = 0;
         foreach (prio[i]) prio[i] = 0;
         foreach (thr[i]) thr[i] = 0;
         errors = 0;
      endfunction

      function void set_reg(csr_type idx, bit [31:0] v);
         case (idx)
            CSR_PRIO_BASE:  prio_base = v[ADDR_W-1:0];
            CSR_PEND_BASE:  pend_base = v[ADDR_W-1:0];
            CSR_EN_BASE:    en_base = v[ADDR_W-1:0];
            CSR_EN_STRIDE:  en_stride = v[STRIDE_W-1:0];
            CSR_CTX_BASE:   ctx_base = v[ADDR_W-1:0];
            CSR_CTX_STRIDE: ctx_stride = v[STRIDE_W-1:0];
            CSR_SOURCES:    sources = v[COUNT_W-1:0];
            CSR_HIGH_THR:   high_thr = v[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function int live_sources();
         return (sources > NSRC) ? NSRC : int'(sources);
      endfunction

      // highest priority eligible source, lowest id on ties
      function int pick_source(int ctx);
         int n;
         int best;
         int bp;
         int w;
         int b;
         n = live_sources();
         best = 0;
         bp = 0;
         for (int id = 1; id < n; id++) begin
            w = id >> 5;
            b = id & 31;
            if (pend[w][b] && !claimed[w][b] && enab[ctx*NWORD+w][b] &&
                prio[id] > thr[ctx] && prio[id] > bp) begin
               best = id;
               bp = int'(prio[id]);
            end
         end
         return best;
      endfunction

      function void note_input(irq_item_type it);
         irq_result_type r;
         int n;
         int words;
         longint a;
         longint off;
         longint rg;
         int ctx;
         int w;
         int id;
         bit mapped;
         bit wr;
         n = live_sources();
         words = (n + 31) >> 5;
         a = it.addr;
         r.rdata = '0;
         r.err = 1'b0;
         r.lines = '0;
         mapped = 0;
         wr = (it.op == OP_WRITE);
         if (it.op == OP_LEVEL) begin
            if (it.src >= 1 && it.src < n) pend[it.src >> 5][it.src & 31] = it.lvl;
         end else if (it.op == OP_READ || it.op == OP_WRITE) begin
            if (it.addr[1:0] != 0) begin
               r.err = 1'b1;
            end else if (a >= prio_base && a < longint'(prio_base) + (n - 1) * 4) begin
               id = int'((a - prio_base) >> 2) + 1;
               mapped = 1;
               if (wr) prio[id] = it.data[THR_W-1:0];
               else r.rdata = 32'(prio[id]);
            end else if (a >= pend_base && a < longint'(pend_base) + words * 4) begin
               w = int'((a - pend_base) >> 2);
               mapped = 1;
               if (wr) r.err = 1'b1;
               else r.rdata = pend[w];
            end else if (en_stride != 0 && a >= en_base &&
                         a < longint'(en_base) + NCTX * longint'(en_stride)) begin
               off = a - en_base;
               ctx = int'(off / en_stride);
               w = int'((off - ctx * longint'(en_stride)) >> 2);
               if (ctx < NCTX && w < words) begin
                  mapped = 1;
                  if (wr) enab[ctx*NWORD+w] = it.data;
                  else r.rdata = enab[ctx*NWORD+w];
               end
            end else if (ctx_stride != 0 && a >= ctx_base &&
                         a < longint'(ctx_base) + NCTX * longint'(ctx_stride)) begin
               off = a - ctx_base;
               ctx = int'(off / ctx_stride);
               rg = off - ctx * longint'(ctx_stride);
               if (ctx < NCTX && rg == 0) begin
                  mapped = 1;
                  if (wr) begin
                     if (it.data <= high_thr) thr[ctx] = it.data[THR_W-1:0];
                  end else begin
                     r.rdata = 32'(thr[ctx]);
                  end
               end else if (ctx < NCTX && rg == CLAIM_OFFSET) begin
                  mapped = 1;
                  if (wr) begin
                     if (it.data < n) claimed[it.data >> 5][it.data & 31] = 0;
                  end else begin
                     id = pick_source(ctx);
                     if (id != 0) begin
                        pend[id >> 5][id & 31] = 0;
                        claimed[id >> 5][id & 31] = 1;
                     end
                     r.rdata = 32'(id);
                  end
               end
            end
            if (it.addr[1:0] == 0 && !mapped) r.err = 1'b1;
            if (wr || r.err) r.rdata = '0;
         end
         for (int c = 0; c < NCTX; c++)
            if (pick_source(c) != 0) r.lines[c] = 1'b1;
         want_q.push_back(r);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(irq_result_type got);
         irq_result_type w;
         if (want_q.size() == 0) begin
            report("response with no transaction outstanding");
         end else begin
            w = want_q.pop_front();
            if (got.rdata !== w.rdata)
               report($sformatf("read_data got %h want %h", got.rdata, w.rdata));
            if (got.err !== w.err)
               report($sformatf("access_error got %b want %b", got.err, w.err));
            if (got.lines !== w.lines)
               report($sformatf("context_interrupts got %b want %b", got.lines, w.lines));
         end
      endtask
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [1:0]         req_opcode = 0;
   logic [ADDR_W-1:0]  req_bus_address = 0;
   logic [DATA_W-1:0]  req_bus_write_data = 0;
   logic [SRCN_W-1:0]  req_source_number = 0;
   logic               req_source_level = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [DATA_W-1:0]  rsp_read_data;
   logic               rsp_access_error;
   logic [LINES_W-1:0] rsp_context_interrupts;
   logic               csr_psel = 0;
   logic               csr_penable = 0;
   logic               csr_pwrite = 0;
   logic [CSR_AW-1:0]  csr_paddr = 0;
   logic [DATA_W-1:0]  csr_pwdata = 0;
   logic [DATA_W-1:0]  csr_prdata;
   logic               csr_pready;

   irq_scoreboard_type sb = new();
   int            cycles = 0;
   int            burst_left = 0;
   int            stall_mode = 0;
   int            stall_run = 0;

   platform_interrupt_controller_top u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // response stall pattern in one of four randomly chosen modes
   always @(posedge clock) begin
      if (cycles % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_run == 0) stall_run = $urandom_range(1, 20);
            stall_run--;
            rsp_stall <= (stall_run > 4);
         end
      endcase
   end

   // note accepted transactions and check responses
   always @(posedge clock) begin
      irq_item_type   it;
      irq_result_type got;
      if (!reset && req_valid && !req_stall) begin
         it.op = op_type'(req_opcode);
         it.addr = req_bus_address;
         it.data = req_bus_write_data;
         it.src = req_source_number;
         it.lvl = req_source_level;
         sb.note_input(it);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got.rdata = rsp_read_data;
         got.err = rsp_access_error;
         got.lines = rsp_context_interrupts;
         sb.check_result(got);
      end
   end

   task send_item(irq_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid <= 1;
      req_opcode <= it.op;
      req_bus_address <= it.addr;
      req_bus_write_data <= it.data;
      req_source_number <= it.src;
      req_source_level <= it.lvl;
      do @(posedge clock); while (!(req_valid && !req_stall));
      burst_left--;
   endtask

   // setup phase, access phase, then an idle phase
   task write_csr(csr_type idx, bit [31:0] v);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= CSR_AW'(idx) << 2;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      sb.set_reg(idx, v);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.want_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   function irq_item_type mk(op_type op, int unsigned a, bit [31:0] d, int s, bit l);
      irq_item_type it;
      it.op = op;
      it.addr = a[ADDR_W-1:0];
      it.data = d;
      it.src = s[SRCN_W-1:0];
      it.lvl = l;
      return it;
   endfunction

   // mostly well-formed register accesses and level changes, some noise
   function irq_item_type random_item();
      irq_item_type it;
      int          n;
      int          words;
      int          k;
      int          ctx;
      int unsigned a;
      n = sb.live_sources();
      words = (n + 31) >> 5;
      it = mk(op_type'($urandom_range(0, 1)), $urandom, $urandom,
              $urandom_range(0, 127), 1'($urandom_range(0, 1)));
      k = $urandom_range(0, 99);
      ctx = $urandom_range(0, NCTX - 1);
      if (k < 25) begin
         it.op = OP_LEVEL;
         it.lvl = ($urandom_range(0, 9) < 7);
         if ($urandom_range(0, 4) != 0) it.src = SRCN_W'($urandom_range(1, n - 1));
      end else if (k < 40) begin
         a = sb.prio_base + 4 * $urandom_range(0, n - 2);
         it.addr = a[ADDR_W-1:0];
         if ($urandom_range(0, 1) == 1) it.data[2:0] = 3'($urandom_range(1, 7));
      end else if (k < 47) begin
         a = sb.pend_base + 4 * $urandom_range(0, words - 1);
         it.addr = a[ADDR_W-1:0];
         if ($urandom_range(0, 5) != 0) it.op = OP_READ;
      end else if (k < 60) begin
         a = sb.en_base + ctx * sb.en_stride + 4 * $urandom_range(0, words);
         it.addr = a[ADDR_W-1:0];
      end else if (k < 70) begin
         a = sb.ctx_base + ctx * sb.ctx_stride;
         it.addr = a[ADDR_W-1:0];
         it.data = $urandom_range(0, 9);
      end else if (k < 90) begin
         a = sb.ctx_base + ctx * sb.ctx_stride + CLAIM_OFFSET;
         it.addr = a[ADDR_W-1:0];
         if ($urandom_range(0, 2) != 0) it.op = OP_READ;
         else if ($urandom_range(0, 7) != 0) it.data = $urandom_range(0, n + 3);
      end else begin
         it.op = op_type'($urandom_range(0, 3));
      end
      return it;
   endfunction

   task run_phase(bit [31:0] regs[8], int count);
      for (int i = 0; i < 8; i++) write_csr(csr_type'(i), regs[i]);
      repeat (count) send_item(random_item());
      drain();
   endtask

   initial begin
      irq_item_type dir_q[$];
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults: priorities, ties, claim and complete, error cases
      run_phase('{4, 4096, 8192, 128, 2097152, 4096, 128, 7}, 0);
      dir_q.push_back(mk(OP_WRITE, 4, 7, 0, 0));
      dir_q.push_back(mk(OP_WRITE, 8, 32'hFFFF_FFFF, 0, 0));
      dir_q.push_back(mk(OP_WRITE, 508, 3, 0, 0));
      dir_q.push_back(mk(OP_WRITE, 8192, 32'hFFFF_FFFF, 0, 0));
      dir_q.push_back(mk(OP_WRITE, 8192 + 3 * 128 + 12, 32'hFFFF_FFFF, 0, 0));
      dir_q.push_back(mk(OP_LEVEL, 0, 0, 2, 1));
      dir_q.push_back(mk(OP_LEVEL, 0, 0, 1, 1));
      dir_q.push_back(mk(OP_LEVEL, 0, 0, 0, 1));
      dir_q.push_back(mk(OP_LEVEL, 0, 0, 127, 1));
      dir_q.push_back(mk(OP_READ, 4096, 0, 0, 0));
      dir_q.push_back(mk(OP_READ, 2097152 + 4, 0, 0, 0));
      dir_q.push_back(mk(OP_READ, 2097152 + 3 * 4096 + 4, 0, 0, 0));
      dir_q.push_back(mk(OP_WRITE, 2097152, 8, 0, 0));
      dir_q.push_back(mk(OP_WRITE, 2097152, 7, 0, 0));
      dir_q.push_back(mk(OP_READ, 2097152, 0, 0, 0));
      dir_q.push_back(mk(OP_WRITE, 2097152 + 4, 1, 0, 0));
      dir_q.push_back(mk(OP_WRITE, 2097152 + 4, 200, 0, 0));
      dir_q.push_back(mk(OP_WRITE, 4096, 1, 0, 0));
      dir_q.push_back(mk(OP_READ, 32'h3FF_FFFF, 0, 0, 0));
      dir_q.push_back(mk(OP_READ, 0, 0, 0, 0));
      dir_q.push_back(mk(OP_READ, 2097152 + 8, 0, 0, 0));
      dir_q.push_back(mk(OP_NOP, 32'h3FF_FFFC, 32'hFFFF_FFFF, 127, 1));
      dir_q.push_back(mk(OP_READ, 8, 0, 0, 0));
      foreach (dir_q[i]) send_item(dir_q[i]);
      drain();

      // several register settings, extremes included
      run_phase('{4, 4096, 8192, 128, 2097152, 4096, 128, 7}, 200);
      run_phase('{0, 32'h400, 32'h800, 16, 32'h1000, 8, 2, 0}, 250);
      run_phase('{32'h100, 32'h300, 32'h400, 65536, 32'h3F0_0000, 65536, 40, 7}, 300);
      run_phase('{32'h3FF_FFFF, 32'h3FF_FFF0, 32'h200, 32, 32'h1_0000, 16, 33, 3}, 250);
      run_phase('{32'h20, 32'h10, 32'h800, 16, 32'h800, 128, 64, 5}, 300);
      run_phase('{4, 4096, 8192, 128, 2097152, 4096, 255, 7}, 180);

      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
